// File: hw/rtl/rbet_pkg.sv
// Shared types and constants for the reconnect backoff and epoch tracker.
`default_nettype none

package rbet_pkg;

    localparam int unsigned CfgWidth = 40;
    localparam int unsigned TimeWidth = 64;
    localparam int unsigned IdWidth = 64;
    localparam int unsigned AttemptWidth = 32;
    localparam int unsigned ShiftWidth = 3;

    localparam logic [ShiftWidth-1:0] ShiftCap = 3'd6;
    localparam logic [TimeWidth-1:0] SignBit = 64'h8000_0000_0000_0000;
    localparam logic [TimeWidth-1:0] Int64Top = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CfgWidth-1:0] BaseBackoffReset = 40'd100000000;
    localparam logic [CfgWidth-1:0] MaxBackoffReset = 40'd5000000000;

    typedef enum logic [1:0] {
        CMD_DISCONNECT = 2'd0,
        CMD_BEGIN_ATTEMPT = 2'd1,
        CMD_ADMIT = 2'd2,
        CMD_MARK_READY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_DISCONNECTED = 2'd0,
        PH_REGISTERING = 2'd1,
        PH_RECOVERING = 2'd2,
        PH_READY = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_INVALID = 3'd1,
        ST_STALE_GENERATION = 3'd2,
        ST_STALE_EPOCH = 3'd3,
        ST_NOT_DUE = 3'd4,
        ST_READY_REFUSED = 3'd5
    } status_t;

    typedef enum logic {
        CFG_BASE_BACKOFF = 1'b0,
        CFG_MAX_BACKOFF = 1'b1
    } cfg_index_t;

    typedef struct packed {
        cmd_t cmd;
        logic signed [TimeWidth-1:0] now;
        logic [IdWidth-1:0] candidate_generation;
        logic [IdWidth-1:0] candidate_epoch;
    } in_item_t;

    typedef struct packed {
        status_t status;
        phase_t phase_now;
        logic [AttemptWidth-1:0] attempt_seen;
        logic retry_ready;
        logic has_authority_out;
        logic [IdWidth-1:0] held_generation;
        logic [IdWidth-1:0] held_epoch;
    } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/reconnect_backoff_epoch_tracker_core.sv
// Top level: reconnect backoff and authority epoch tracker for one peer.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  in      | into core | in_valid / in_ready      | in_item  (rbet_pkg::in_item_t)
//  out     | from core | out_valid / out_ready    | out_item (rbet_pkg::out_item_t)
//  cfg     | into core | cfg_valid / cfg_ready    | cfg_index, cfg_data (40 bits)
//
// One command per cycle while out_ready holds: an accepted beat sits in the input register, is
// resolved in one pass against the tracker state and moves into the result register on advance.
// out_valid rises as the beat enters the result register; the state updates as a beat moves.
// A stalled result holds the state; one more beat fills the input register behind it,
// then in_ready drops until out_ready returns.
// Reset clears tracker state and loads the default backoff registers; cfg_ready is high.
`default_nettype none

module reconnect_backoff_epoch_tracker_core (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  rbet_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  wire                             out_ready,
    output rbet_pkg::out_item_t             out_item,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  rbet_pkg::cfg_index_t            cfg_index,
    input  wire [rbet_pkg::CfgWidth-1:0]    cfg_data
);
    import rbet_pkg::*;

    logic                           in_valid_reg;
    in_item_t                       in_item_reg;
    logic                           out_valid_reg;
    out_item_t                      out_item_reg;
    out_item_t                      out_item_next;

    logic [CfgWidth-1:0]            base_reg;
    logic [CfgWidth-1:0]            max_reg;

    phase_t                         phase_reg;
    phase_t                         phase_next;
    logic [AttemptWidth-1:0]        attempt_reg;
    logic [AttemptWidth-1:0]        attempt_next;
    logic signed [TimeWidth-1:0]    due_reg;
    logic signed [TimeWidth-1:0]    due_next;
    logic                           auth_reg;
    logic                           auth_next;
    logic [IdWidth-1:0]             gen_reg;
    logic [IdWidth-1:0]             gen_next;
    logic [IdWidth-1:0]             epoch_reg;
    logic [IdWidth-1:0]             epoch_next;

    logic                           advance;
    logic                           due_now;
    logic [ShiftWidth-1:0]          shift_amt;
    logic [CfgWidth+5:0]            shifted;
    logic [CfgWidth-1:0]            delay;
    logic [TimeWidth:0]             biased_sum;
    logic [TimeWidth-1:0]           scheduled;
    logic [AttemptWidth-1:0]        attempt_inc;
    status_t                        admit_status;
    status_t                        status;
    logic                           retry_ready;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Retry check against the state before this command.
    assign due_now = (phase_reg != PH_READY) && (in_item_reg.now >= due_reg);

    // Shift taken after the bump equals min(old count, 6).
    assign shift_amt = (attempt_reg >= AttemptWidth'(ShiftCap)) ? ShiftCap
                                                                : attempt_reg[ShiftWidth-1:0];
    assign shifted   = {6'd0, base_reg} << shift_amt;
    assign delay     = (shifted < {6'd0, max_reg}) ? shifted[CfgWidth-1:0] : max_reg;

    // Add in offset-binary form; a carry out means the signed sum passed int64 max.
    assign biased_sum = {1'b0, in_item_reg.now ^ SignBit} + {25'd0, delay};
    assign scheduled  = biased_sum[TimeWidth] ? Int64Top : (biased_sum[TimeWidth-1:0] ^ SignBit);

    assign attempt_inc = (&attempt_reg) ? attempt_reg : attempt_reg + AttemptWidth'(1);

    always_comb
    begin
        if (in_item_reg.candidate_generation == '0 || in_item_reg.candidate_epoch == '0)
            admit_status = ST_INVALID;
        else if (auth_reg && in_item_reg.candidate_generation < gen_reg)
            admit_status = ST_STALE_GENERATION;
        else if (auth_reg && in_item_reg.candidate_generation == gen_reg
                 && in_item_reg.candidate_epoch <= epoch_reg)
            admit_status = ST_STALE_EPOCH;
        else
            admit_status = ST_OK;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        attempt_next = attempt_reg;
        due_next     = due_reg;
        auth_next    = auth_reg;
        gen_next     = gen_reg;
        epoch_next   = epoch_reg;
        status       = ST_OK;
        retry_ready  = due_now;
        unique case (in_item_reg.cmd)
            CMD_DISCONNECT:
            begin
                phase_next   = PH_DISCONNECTED;
                attempt_next = '0;
                due_next     = in_item_reg.now;
                retry_ready  = 1'b1;
            end
            CMD_BEGIN_ATTEMPT:
            begin
                if (!due_now)
                begin
                    status = ST_NOT_DUE;
                end
                else
                begin
                    phase_next   = PH_REGISTERING;
                    attempt_next = attempt_inc;
                    due_next     = scheduled;
                    // Still due only for a zero delay or a time pinned at int64 max.
                    retry_ready  = (delay == '0) || (in_item_reg.now == Int64Top);
                end
            end
            CMD_ADMIT:
            begin
                status = admit_status;
                if (admit_status == ST_OK)
                begin
                    auth_next    = 1'b1;
                    gen_next     = in_item_reg.candidate_generation;
                    epoch_next   = in_item_reg.candidate_epoch;
                    phase_next   = PH_RECOVERING;
                    attempt_next = '0;
                    due_next     = in_item_reg.now;
                    retry_ready  = 1'b1;
                end
            end
            CMD_MARK_READY:
            begin
                if (phase_reg != PH_RECOVERING)
                begin
                    status = ST_READY_REFUSED;
                end
                else
                begin
                    phase_next  = PH_READY;
                    retry_ready = 1'b0;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_item_next.status            = status;
        out_item_next.phase_now         = phase_next;
        out_item_next.attempt_seen      = (attempt_next == '0) ? AttemptWidth'(1) : attempt_next;
        out_item_next.retry_ready       = retry_ready;
        out_item_next.has_authority_out = auth_next;
        out_item_next.held_generation   = gen_next;
        out_item_next.held_epoch        = epoch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= BaseBackoffReset;
            max_reg       <= MaxBackoffReset;
            phase_reg     <= PH_DISCONNECTED;
            attempt_reg   <= '0;
            due_reg       <= '0;
            auth_reg      <= 1'b0;
            gen_reg       <= '0;
            epoch_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BASE_BACKOFF: base_reg <= cfg_data;
                    CFG_MAX_BACKOFF:  max_reg  <= cfg_data;
                    default:          base_reg <= base_reg;
                endcase
            end
            if (advance)
            begin
                phase_reg   <= phase_next;
                attempt_reg <= attempt_next;
                due_reg     <= due_next;
                auth_reg    <= auth_next;
                gen_reg     <= gen_next;
                epoch_reg   <= epoch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rbet_checker.sv
// Port-level checks for the reconnect backoff tracker, bound to the top level.
`default_nettype none

module rbet_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  out_valid,
    input wire                  out_ready,
    input rbet_pkg::out_item_t  out_item
);
    import rbet_pkg::*;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result beat changed while stalled");

    // A peer in ready phase is never due for a retry.
    a_ready_not_due: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.phase_now == PH_READY |-> !out_item.retry_ready)
        else $error("retry_ready set in ready phase");

    // A successful admit leaves a held authority, a fresh count and an immediate retry.
    a_admit_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_OK && out_item.phase_now == PH_RECOVERING
        |-> out_item.has_authority_out && out_item.retry_ready
            && out_item.attempt_seen == AttemptWidth'(1))
        else $error("admit result inconsistent");

    // A disconnect clears the count and makes a retry due at once.
    a_disconnect_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == ST_OK && out_item.phase_now == PH_DISCONNECTED
        |-> out_item.retry_ready && out_item.attempt_seen == AttemptWidth'(1))
        else $error("disconnect result inconsistent");

    // A stale generation can only be reported against a held authority.
    a_stale_needs_authority: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_STALE_GENERATION
                      || out_item.status == ST_STALE_EPOCH)
        |-> out_item.has_authority_out)
        else $error("stale status without held authority");

endmodule

bind reconnect_backoff_epoch_tracker_core rbet_checker u_rbet_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
